### sv/rkte_pkg.sv
// Shared types, widths and constants for the response key trigger encoder.
`timescale 1ns / 1ps

package rkte_pkg;

    // Register indexes on the configuration channel
    localparam logic CFG_REPRESS_TICKS = 1'b0;
    localparam logic CFG_TRIGGER_HOLD  = 1'b1;

    // Register reset values
    localparam logic [7:0] REPRESS_RESET = 8'd10;
    localparam logic [7:0] HOLD_RESET    = 8'd10;

    // Key layout: four response keys, then the trigger key
    localparam int RESP_KEYS = 4;
    localparam int TRIG_IDX  = 4;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // One input item
    typedef struct packed {
        logic [3:0] sim_flags;
        logic       trigger_request;
        logic       sim_mode;
        logic       manual_mode;
        logic       session_on;
        logic [3:0] pin_levels;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [3:0] sim_clear_mask;
        logic       trigger_clear;
        logic       beep_start;
        logic       sync_beep_start;
        logic       report_strobe;
        logic [4:0] key_bitmap;
    } t_out_item;

    // Encoder state carried from tick to tick
    typedef struct packed {
        logic [4:0] key_down;
        logic [7:0] hold_count;
        logic [7:0] lockout_count;
    } t_state;

    // Configuration register values
    typedef struct packed {
        logic [7:0] repress_ticks;
        logic [7:0] trigger_hold_ticks;
    } t_cfg;

endpackage

### sv/rkte_cfg.sv
// Configuration register bank for the response key trigger encoder.
`timescale 1ns / 1ps

module rkte_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic              i_wr_addr,
    input  logic [7:0]        i_wr_data,
    output rkte_pkg::t_cfg    o_cfg
);

    logic [7:0] r_repress;
    logic [7:0] r_hold;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repress <= rkte_pkg::REPRESS_RESET;
            r_hold    <= rkte_pkg::HOLD_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_addr)
                rkte_pkg::CFG_REPRESS_TICKS: r_repress <= i_wr_data;
                rkte_pkg::CFG_TRIGGER_HOLD:  r_hold    <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.repress_ticks      = r_repress;
    assign o_cfg.trigger_hold_ticks = r_hold;

endmodule

### sv/rkte_tick.sv
// Per-tick key update: next encoder state and the result item.
`timescale 1ns / 1ps

module rkte_tick (
    input  rkte_pkg::t_in_item  i_item,
    input  rkte_pkg::t_state    i_state,
    input  rkte_pkg::t_cfg      i_cfg,
    output rkte_pkg::t_state    o_state,
    output rkte_pkg::t_out_item o_res
);

    logic       active;
    logic [7:0] lock_dec;
    logic [7:0] hold_inc;
    logic [3:0] src;
    logic [3:0] pressed;
    logic       trig_down;

    assign active    = i_item.session_on | i_item.manual_mode | i_item.sim_mode;
    assign lock_dec  = (i_state.lockout_count != 8'd0) ? i_state.lockout_count - 8'd1 : 8'd0;
    assign hold_inc  = i_state.hold_count + 8'd1;
    assign trig_down = i_state.key_down[rkte_pkg::TRIG_IDX];
    assign src       = i_item.session_on ? i_item.pin_levels : i_item.sim_flags;
    assign pressed   = src & ~i_state.key_down[3:0];

    always_comb begin
        o_state                 = i_state;
        o_state.lockout_count   = lock_dec;
        o_res                   = '0;

        if (!active) begin
            // Idle mode: release everything, keep the hold count
            o_state.key_down = 5'd0;
        end else if (i_item.trigger_request) begin
            if (!trig_down) begin
                // Press the trigger key
                o_state.key_down[rkte_pkg::TRIG_IDX] = 1'b1;
                o_res.sync_beep_start = i_item.session_on;
            end else if (hold_inc > i_cfg.trigger_hold_ticks) begin
                // Hold finished: ask software to drop its request
                o_res.trigger_clear = 1'b1;
                o_state.hold_count  = 8'd0;
            end else begin
                o_state.hold_count = hold_inc;
            end
        end else if (trig_down) begin
            // Release all keys and start the repress lockout
            o_state.key_down      = 5'd0;
            o_state.lockout_count = i_cfg.repress_ticks;
        end else if (lock_dec == 8'd0) begin
            // Response keys follow the selected source
            o_state.key_down[3:0] = src;
            if (i_item.session_on) begin
                o_res.sim_clear_mask = pressed;
                o_res.beep_start     = |pressed;
            end
        end

        o_res.key_bitmap    = o_state.key_down;
        o_res.report_strobe = (o_state.key_down != i_state.key_down);
    end

endmodule

### sv/response_key_trigger_encoder_core.sv
// Top level of the response key trigger encoder: handshakes, state and result register.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-----------------------------------
//  s (ticks) | in        | i_s_tvalid / o_s_tready | i_s_tdata  (16b, one tick's inputs)
//  m (result)| out       | o_m_tvalid / i_m_tready | o_m_tdata  (16b, key result)
//  cfg       | in        | i_cfg_valid/o_cfg_ready | i_cfg_addr, i_cfg_data
//
//  Each tick is worked out combinationally: the state and the result register load
//  at the edge that accepts the item, and the result shows on the next cycle.
//  A new tick is taken every cycle while the result register is empty or drained.
//  Synchronous active-low reset releases all keys and zeroes both counters;
//  both configuration registers return to 10. A stalled output holds its item.
`timescale 1ns / 1ps

module response_key_trigger_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input: [3:0] pin_levels, [4] session_on, [5] manual_mode,
    // [6] sim_mode, [7] trigger_request, [11:8] sim_flags, [15:12] zero
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [rkte_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // Result: [4:0] key_bitmap, [5] report_strobe, [6] sync_beep_start,
    // [7] beep_start, [8] trigger_clear, [12:9] sim_clear_mask, [15:13] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [rkte_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    rkte_pkg::t_cfg      cfg;
    rkte_pkg::t_in_item  item;
    rkte_pkg::t_state    r_state;
    rkte_pkg::t_state    n_state;
    rkte_pkg::t_out_item n_res;
    rkte_pkg::t_out_item r_res;
    logic                r_valid;
    logic                accept;

    assign o_cfg_ready = 1'b1;

    rkte_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_addr (i_cfg_addr),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    assign item = rkte_pkg::t_in_item'(i_s_tdata[$bits(rkte_pkg::t_in_item)-1:0]);

    rkte_tick u_tick (
        .i_item  (item),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Take a tick when the result register is free or being drained
    assign o_s_tready = i_rst_n & (~r_valid | i_m_tready);
    assign accept     = i_s_tvalid & o_s_tready;

    // Advance the key state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(rkte_pkg::OUT_TDATA_W - $bits(rkte_pkg::t_out_item)){1'b0}}, r_res};

endmodule

### sv/rkte_chk.sv
// Port-level checker for the response key trigger encoder, bound to the top level.
`timescale 1ns / 1ps

module rkte_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // A stalled result item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // Every accepted item shows a result on the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted item produced no result");

    // Trigger clear only while the trigger key is down
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tdata[4] && !o_m_tdata[5])
        else $error("trigger clear without held trigger key");

    // Sync beep comes with a fresh trigger press and a report
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[6] |-> o_m_tdata[4] && o_m_tdata[5] && !o_m_tdata[7])
        else $error("sync beep without trigger press report");

    // Cleared sim flags match pressed keys and a beep
    a_simclr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[12:9] != 4'd0) |->
            o_m_tdata[7] && o_m_tdata[5] && ((o_m_tdata[12:9] & ~o_m_tdata[3:0]) == 4'd0))
        else $error("sim clear mask without matching key press");

endmodule

bind response_key_trigger_encoder_core rkte_chk u_rkte_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/rkte_checker.sv
// Checker for the response key trigger encoder: tracks the tick stream, predicts and compares.
`timescale 1ns / 1ps

module rkte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_clears
);

    // Shadow of the encoder: key state, counters and register values
    logic [4:0]          keys_down;
    logic [7:0]          hold_cnt;
    logic [7:0]          lockout_cnt;
    rkte_pkg::t_cfg      regs;

    rkte_pkg::t_out_item expected_keys[$];
    int                  mismatches;
    int                  checked;
    int                  clears;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    // Advance the shadow state by one frame tick and return the result it yields
    function automatic rkte_pkg::t_out_item encode_tick(input rkte_pkg::t_in_item tick);
        rkte_pkg::t_out_item res;
        logic [4:0]          prior;
        logic [3:0]          src;
        logic                active;
        res    = '0;
        prior  = keys_down;
        active = tick.session_on | tick.manual_mode | tick.sim_mode;

        // Lockout counts down before anything else
        if (lockout_cnt != 8'd0) begin
            lockout_cnt = lockout_cnt - 8'd1;
        end

        if (!active) begin
            keys_down = '0;
        end else if (tick.trigger_request) begin
            if (!keys_down[rkte_pkg::TRIG_IDX]) begin
                keys_down[rkte_pkg::TRIG_IDX] = 1'b1;
                res.sync_beep_start = tick.session_on;
            end else begin
                // 8-bit hold count wraps, so a register of 255 never clears
                hold_cnt = hold_cnt + 8'd1;
                if (hold_cnt > regs.trigger_hold_ticks) begin
                    res.trigger_clear = 1'b1;
                    hold_cnt = '0;
                end
            end
        end else if (keys_down[rkte_pkg::TRIG_IDX]) begin
            // Trigger dropped: release everything and start the lockout
            keys_down   = '0;
            lockout_cnt = regs.repress_ticks;
        end else if (lockout_cnt == 8'd0) begin
            src = tick.session_on ? tick.pin_levels : tick.sim_flags;
            for (int k = 0; k < rkte_pkg::RESP_KEYS; k++) begin
                if (src[k] && !keys_down[k]) begin
                    keys_down[k] = 1'b1;
                    if (tick.session_on) begin
                        res.sim_clear_mask[k] = 1'b1;
                        res.beep_start        = 1'b1;
                    end
                end else if (!src[k]) begin
                    keys_down[k] = 1'b0;
                end
            end
        end

        res.key_bitmap    = keys_down;
        res.report_strobe = (keys_down != prior);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        rkte_pkg::t_in_item  tick;
        rkte_pkg::t_out_item got;
        rkte_pkg::t_out_item want;
        if (!i_rst_n) begin
            keys_down   = '0;
            hold_cnt    = '0;
            lockout_cnt = '0;
            regs.repress_ticks      = rkte_pkg::REPRESS_RESET;
            regs.trigger_hold_ticks = rkte_pkg::HOLD_RESET;
            expected_keys.delete();
            mismatches = 0;
            checked    = 0;
            clears     = 0;
        end else begin
            // Predict on every accepted tick item with the registers as they stood
            if (i_s_tvalid && i_s_tready) begin
                tick = i_s_tdata[11:0];
                expected_keys.push_back(encode_tick(tick));
            end

            // Register writes take effect for the ticks after this edge
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr == rkte_pkg::CFG_REPRESS_TICKS) begin
                    regs.repress_ticks = i_cfg_data;
                end else begin
                    regs.trigger_hold_ticks = i_cfg_data;
                end
            end

            // Compare each accepted result with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[12:0];
                if (got.trigger_clear) begin
                    clears++;
                end
                if (i_m_tdata[15:13] != 3'b000) begin
                    report_mismatch($sformatf("result %0d padding bits 0x%0h not zero",
                                              checked, i_m_tdata[15:13]));
                end
                if (expected_keys.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h arrived with nothing expected",
                                              i_m_tdata));
                end else begin
                    want = expected_keys.pop_front();
                    if (got.key_bitmap != want.key_bitmap)
                        report_mismatch($sformatf("result %0d key_bitmap got 0x%0h exp 0x%0h",
                                                  checked, got.key_bitmap, want.key_bitmap));
                    if (got.report_strobe != want.report_strobe)
                        report_mismatch($sformatf("result %0d report_strobe got %0d exp %0d",
                                                  checked, got.report_strobe,
                                                  want.report_strobe));
                    if (got.sync_beep_start != want.sync_beep_start)
                        report_mismatch($sformatf("result %0d sync_beep_start got %0d exp %0d",
                                                  checked, got.sync_beep_start,
                                                  want.sync_beep_start));
                    if (got.beep_start != want.beep_start)
                        report_mismatch($sformatf("result %0d beep_start got %0d exp %0d",
                                                  checked, got.beep_start, want.beep_start));
                    if (got.trigger_clear != want.trigger_clear)
                        report_mismatch($sformatf("result %0d trigger_clear got %0d exp %0d",
                                                  checked, got.trigger_clear,
                                                  want.trigger_clear));
                    if (got.sim_clear_mask != want.sim_clear_mask)
                        report_mismatch($sformatf("result %0d sim_clear_mask got 0x%0h exp 0x%0h",
                                                  checked, got.sim_clear_mask,
                                                  want.sim_clear_mask));
                end
                checked++;
            end
        end

        o_fail_count <= mismatches;
        o_pending    <= expected_keys.size();
        o_checked    <= checked;
        o_clears     <= clears;
    end

endmodule

### tb/response_key_trigger_encoder_core_tb.sv
// Testbench top for the response key trigger encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module response_key_trigger_encoder_core_tb;

    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        MODE_RUN,
        MODE_MANUAL,
        MODE_SIM,
        MODE_IDLE
    } t_key_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_addr  = 1'b0;
    logic [7:0]  i_cfg_data  = '0;

    int          fails;
    int          pending;
    int          checked;
    int          clears;

    // Shadow register values that shape the trigger sequences
    logic [7:0]  repress_shadow = rkte_pkg::REPRESS_RESET;
    logic [7:0]  hold_shadow    = rkte_pkg::HOLD_RESET;

    bit          calm = 1'b0;
    int          items_sent = 0;
    int          settings = 1;
    int          idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    response_key_trigger_encoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    rkte_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_clears     (clears)
    );

    // Abort when no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall a random number of cycles before each item
    initial begin : drain_results
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Offer one tick item after a random gap and hold it until accepted
    task automatic send_tick(input rkte_pkg::t_in_item tick);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {4'b0000, tick};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // Build a tick for a mode; lower-priority mode flags are random where they do not matter
    function automatic rkte_pkg::t_in_item make_tick(input t_key_mode mode, input logic req,
                                                     input logic [3:0] pins,
                                                     input logic [3:0] sims);
        rkte_pkg::t_in_item tick;
        tick.pin_levels      = pins;
        tick.sim_flags       = sims;
        tick.trigger_request = req;
        tick.session_on      = (mode == MODE_RUN);
        tick.manual_mode     = (mode == MODE_MANUAL) ? 1'b1 :
                               (mode == MODE_IDLE) ? 1'b0 : 1'($urandom_range(0, 1));
        tick.sim_mode        = (mode == MODE_SIM) ? 1'b1 :
                               (mode == MODE_IDLE) ? 1'b0 : 1'($urandom_range(0, 1));
        return tick;
    endfunction

    task automatic put(input t_key_mode mode, input logic req,
                       input logic [3:0] pins, input logic [3:0] sims);
        send_tick(make_tick(mode, req, pins, sims));
    endtask

    // Mostly well-formed ticks with random key content; some fully random noise
    task automatic put_noisy(input t_key_mode mode, input logic req, input bit clean);
        logic [11:0] raw;
        if (!clean && $urandom_range(0, 11) == 0) begin
            raw = 12'($urandom());
            send_tick(raw);
        end else begin
            put(mode, req, 4'($urandom()), 4'($urandom()));
        end
    endtask

    function automatic t_key_mode pick_mode(input bit active_only);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 || (active_only && r == 9)) return MODE_RUN;
        if (r < 7) return MODE_MANUAL;
        if (r < 9) return MODE_SIM;
        return MODE_IDLE;
    endfunction

    // One press cycle: free key activity, trigger hold, release and lockout
    task automatic run_press_cycle(input bit clean);
        t_key_mode mode;
        int        n;
        int        hold_len;
        int        lock_len;
        mode = pick_mode(clean);
        n = $urandom_range(1, 8);
        repeat (n) put_noisy(mode, 1'b0, clean);

        hold_len = int'(hold_shadow) + 2;
        if (hold_shadow == 8'hFF) begin
            hold_len = 300;
        end else if (!clean) begin
            case ($urandom_range(0, 5))
                0: hold_len = $urandom_range(1, int'(hold_shadow) + 1);
                1: hold_len += $urandom_range(1, 6);
                default: ;
            endcase
        end
        repeat (hold_len) put_noisy(mode, 1'b1, clean);

        lock_len = int'(repress_shadow) + $urandom_range(1, 4);
        repeat (lock_len) put_noisy(mode, 1'b0, clean);
    endtask

    // Hold the tick stream until every expected result is back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers back to back on the configuration channel
    task automatic write_regs(input logic [7:0] repress, input logic [7:0] hold);
        i_cfg_addr  <= rkte_pkg::CFG_REPRESS_TICKS;
        i_cfg_data  <= repress;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_addr  <= rkte_pkg::CFG_TRIGGER_HOLD;
        i_cfg_data  <= hold;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        repress_shadow = repress;
        hold_shadow    = hold;
    endtask

    task automatic run_phase(input logic [7:0] repress, input logic [7:0] hold,
                             input int budget, input bit clean);
        int start;
        settle();
        write_regs(repress, hold);
        settings++;
        start = items_sent;
        if (clean) begin
            run_press_cycle(1'b1);
        end else begin
            while (items_sent - start < budget) run_press_cycle(1'b0);
        end
    endtask

    initial begin : stimulus
        rkte_pkg::t_in_item tick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks with the registers at their reset values
        put(MODE_IDLE, 1'b1, 4'hF, 4'hF);
        put(MODE_RUN, 1'b0, 4'hF, 4'h0);
        put(MODE_RUN, 1'b0, 4'h0, 4'hF);
        put(MODE_MANUAL, 1'b0, 4'h0, 4'hF);
        put(MODE_SIM, 1'b0, 4'hF, 4'h5);
        // Running wins over manual and simulation flags
        tick = make_tick(MODE_RUN, 1'b0, 4'hA, 4'h5);
        tick.manual_mode = 1'b1;
        tick.sim_mode    = 1'b1;
        send_tick(tick);
        put(MODE_IDLE, 1'b0, 4'hF, 4'hF);
        // Trigger press, full hold to the clear, request kept past the clear
        put(MODE_RUN, 1'b1, 4'h0, 4'h0);
        repeat (11) put(MODE_RUN, 1'b1, 4'($urandom()), 4'($urandom()));
        put(MODE_RUN, 1'b1, 4'hF, 4'hF);
        // Release, then pins ignored under lockout, idle during lockout
        put(MODE_RUN, 1'b0, 4'hF, 4'hF);
        put(MODE_RUN, 1'b0, 4'hF, 4'hF);
        put(MODE_IDLE, 1'b0, 4'hF, 4'hF);
        // Trigger in manual mode gives no sync beep
        put(MODE_MANUAL, 1'b1, 4'h0, 4'h0);
        put(MODE_MANUAL, 1'b0, 4'h0, 4'h0);

        // Random press cycles across register settings, extremes first
        run_phase(8'd0, 8'd0, 200, 1'b0);
        calm = 1'b1;
        run_phase(8'd255, 8'd0, 0, 1'b1);
        calm = 1'b0;
        run_phase(8'd0, 8'd254, 0, 1'b1);
        run_phase(8'd2, 8'd255, 0, 1'b1);
        for (int p = 0; p < 5; p++) begin
            calm = (p == 2);
            run_phase(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)), 120, 1'b0);
        end
        calm = 1'b0;

        settle();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ticks over %0d register settings, lockout and hold up to 255.",
                 items_sent, settings);
        $display("Checked %0d results, %0d of them trigger clears.", checked, clears);
        if (fails == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
sv/rkte_pkg.sv
sv/rkte_cfg.sv
sv/rkte_tick.sv
sv/response_key_trigger_encoder_core.sv
sv/rkte_chk.sv
tb/rkte_checker.sv
tb/response_key_trigger_encoder_core_tb.sv
